// ===== rtl/assert_macros.svh =====
// assertion helpers, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== rtl/stkmid_pkg.sv =====
package stkmid_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [IDX_W-1:0]  idx_t;

	typedef enum logic [1:0] {
		OP_PUSH     = 2'd0,
		OP_POP      = 2'd1,
		OP_READ_MID = 2'd2,
		OP_DEL_MID  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cell load controls
	typedef struct packed {
		logic load_prev;   // take the entry from the cell above (push)
		logic load_next;   // take the entry from the cell below (close a gap)
	} cell_ctrl_t;

endpackage

// ===== rtl/stkmid_cell.sv =====
module stkmid_cell (
	input  logic                   clk,
	input  stkmid_pkg::cell_ctrl_t ctrl,
	input  stkmid_pkg::data_t      prev_data,
	input  stkmid_pkg::data_t      next_data,
	output stkmid_pkg::data_t      data
);

	stkmid_pkg::data_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_prev) begin
			data_q <= prev_data;
		end else if (ctrl.load_next) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

// ===== rtl/stack_with_middle_access.sv =====
// stack with access to its middle entry
//
// input channel (in_valid / in_stall) carries one operation per transaction:
// op selects push, pop top, read middle or delete middle; push_value is used
// by push only. output channel (out_valid / out_stall) returns exactly one
// transaction per operation: result_value, status and the occupancy after
// the operation.
//
// the registered result appears in the cycle after an operation is accepted.
// throughput: one operation per cycle while the receiver does not stall;
// every operation finishes in a single parallel load of the cell row, so
// nothing iterates. if the receiver stalls, the result is held in the
// output register and in_stall rises until that result is taken.
//
// reset clears the entry count and the output valid; the cell contents are
// not cleared, since cells at or beyond the count are never read.
// the middle entry is position floor((count-1)/2) from the top; a delete
// there makes every deeper entry move one cell toward the top.
`include "assert_macros.svh"

module stack_with_middle_access (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] push_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_value,
	output logic [1:0]  status,
	output logic [4:0]  occupancy
);

	localparam int DEPTH = stkmid_pkg::DEPTH;

	// entry count and output register
	stkmid_pkg::cnt_t    count_q;
	logic                out_valid_q;
	stkmid_pkg::data_t   result_q;
	stkmid_pkg::status_t status_q;
	stkmid_pkg::cnt_t    occ_q;

	// decode of the current operation
	logic                accept;
	stkmid_pkg::op_t     op_c;
	logic                push_ok;
	logic                remove;
	stkmid_pkg::idx_t    rm_pos;
	stkmid_pkg::idx_t    mid;
	stkmid_pkg::cnt_t    cnt_m1;
	stkmid_pkg::cnt_t    cnt_nxt;
	stkmid_pkg::data_t   res_val;
	stkmid_pkg::status_t res_st;

	// cell row
	stkmid_pkg::data_t      cell_data [DEPTH];
	stkmid_pkg::cell_ctrl_t cell_ctrl [DEPTH];

	// a new transaction enters whenever the output register is free or drains
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign op_c   = stkmid_pkg::op_t'(op);
	assign cnt_m1 = count_q - 1'b1;
	assign mid    = stkmid_pkg::idx_t'(cnt_m1 >> 1);

	always_comb begin
		push_ok = 1'b0;
		remove  = 1'b0;
		rm_pos  = '0;
		res_val = '0;
		res_st  = stkmid_pkg::ST_OK;
		cnt_nxt = count_q;
		unique case (op_c)
			stkmid_pkg::OP_PUSH: begin
				if (count_q == stkmid_pkg::CNT_W'(DEPTH)) begin
					res_st = stkmid_pkg::ST_FULL;
				end else begin
					push_ok = 1'b1;
					cnt_nxt = count_q + 1'b1;
				end
			end
			stkmid_pkg::OP_POP: begin
				if (count_q == '0) begin
					res_st = stkmid_pkg::ST_EMPTY;
				end else begin
					remove  = 1'b1;
					res_val = cell_data[0];
					cnt_nxt = cnt_m1;
				end
			end
			stkmid_pkg::OP_READ_MID: begin
				if (count_q == '0) begin
					res_st = stkmid_pkg::ST_EMPTY;
				end else begin
					res_val = cell_data[mid];
				end
			end
			stkmid_pkg::OP_DEL_MID: begin
				if (count_q == '0) begin
					res_st = stkmid_pkg::ST_EMPTY;
				end else begin
					// with two entries mid is the top, so the old second one becomes top
					remove  = 1'b1;
					rm_pos  = mid;
					res_val = cell_data[mid];
					cnt_nxt = cnt_m1;
				end
			end
			default: begin
				res_st = stkmid_pkg::ST_OK;
			end
		endcase
	end

	// row of cells: a push shifts every cell down by one, a removal shifts
	// the cells at and below the removed position up by one
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		stkmid_pkg::data_t prev_d;
		stkmid_pkg::data_t next_d;

		if (i == 0) begin : g_top
			assign prev_d = push_value[stkmid_pkg::DATA_W-1:0];
		end else begin : g_inner_prev
			assign prev_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_bottom
			assign next_d = cell_data[i];
		end else begin : g_inner_next
			assign next_d = cell_data[i+1];
		end

		assign cell_ctrl[i].load_prev = accept && push_ok;
		assign cell_ctrl[i].load_next = accept && remove &&
			(stkmid_pkg::idx_t'(i) >= rm_pos);

		stkmid_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[i]),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cell_data[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_val;
			status_q <= res_st;
			occ_q    <= cnt_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

	// checks
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= stkmid_pkg::CNT_W'(DEPTH), "count above depth")
	`ASSERT_NEXT(a_push_grows, clk, arst_n, accept && push_ok, count_q == $past(count_q) + 1'b1, "push did not grow count")
	`ASSERT_NEXT(a_remove_shrinks, clk, arst_n, accept && remove, count_q == $past(count_q) - 1'b1, "removal did not shrink count")
	`ASSERT_ALWAYS(a_full_occ, clk, arst_n, !(out_valid_q && status_q == stkmid_pkg::ST_FULL) || occ_q == stkmid_pkg::CNT_W'(DEPTH), "full status without full stack")

endmodule
